// ----- hdl/wpe_pkg.sv -----
// ----------------------------------------------------------------------------
// wpe_pkg
// types and constants shared by the window pooling engine
// ----------------------------------------------------------------------------
package wpe_pkg;

    localparam int PIXEL_BITS     = 16;
    localparam int PIX_W          = 16;
    localparam int ACC_W          = 22;
    localparam int OCOL_W         = 8;
    localparam int ROW_W          = 12;
    localparam int WS_W           = 4;
    localparam int OW_W           = 9;
    localparam int OH_W           = 13;
    localparam int MODE_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int WS_EFF_W       = WS_W + 1;
    localparam int DIVR_W         = 2 * WS_EFF_W;
    localparam int DCNT_W         = $clog2(ACC_W);
    localparam int MAX_OUT_HEIGHT = 4096;

    localparam logic [PIX_W-1:0] PIX_MASK =
        (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);

    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_word;

    typedef struct packed {
        logic [PIX_W-1:0]  pooled_value;
        logic [OCOL_W-1:0] out_col;
        logic [ROW_W-1:0]  out_row;
        logic              last_of_frame;
    } t_res_word;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic calc;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic avg;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/wpe_ram.sv -----
// ----------------------------------------------------------------------------
// wpe_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wpe_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/wpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpe_ctrl
// sequencer for one pixel: read, combine, divide, hand off result
// ----------------------------------------------------------------------------
module wpe_ctrl import wpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pix_valid,
    output logic       o_pix_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_pix_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (!i_status.emit) begin
                    n_state = S_IDLE;
                end else if (i_status.avg) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_pix_valid;
        o_cmd.rd_en    = (r_state == S_READ);
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_OUT) && i_status.out_free;
    end

    assign o_pix_stall = (r_state != S_IDLE);

endmodule

// ----- hdl/wpe_dp.sv -----
// ----------------------------------------------------------------------------
// wpe_dp
// datapath: registers, position counters, column accumulators, divider,
// output word register
// ----------------------------------------------------------------------------
module wpe_dp import wpe_pkg::*; #(
    parameter int MAX_OUT_WIDTH = 256,
    parameter int MAX_WINDOW    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_pix_word             i_pix,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_res_stall,
    output logic                  o_res_valid,
    output t_res_word             o_res
);

    localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int WIN_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [WS_W-1:0]   r_ws;
    logic [OW_W-1:0]   r_ow;
    logic [OH_W-1:0]   r_oh;
    logic [MODE_W-1:0] r_mode;

    logic [WS_EFF_W-1:0] ws_eff;
    logic [OH_W-1:0]     ow_eff;
    logic [OH_W-1:0]     oh_eff;

    logic [WIN_W-1:0] r_ciw;
    logic [WIN_W-1:0] r_riw;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [WIN_W-1:0] n_ciw;
    logic [WIN_W-1:0] n_riw;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [PIX_W-1:0] r_pix;
    logic [ACC_W-1:0] rd_data;
    logic [ACC_W-1:0] pix_ext;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] r_acc;
    logic [OH_W-1:0]  col_ext;

    logic last_ciw;
    logic last_riw;
    logic last_col;
    logic last_row;

    logic [OCOL_W-1:0] r_emit_col;
    logic [ROW_W-1:0]  r_emit_row;
    logic              r_emit_last;

    logic [ACC_W-1:0]  r_dvd;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_divisor;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W:0]   rem_diff;
    logic              q_bit;
    logic [DIVR_W-1:0] n_rem;

    logic [PIX_W-1:0] n_value;
    logic             r_out_valid;
    t_res_word        r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= WS_W'(2);
            r_ow   <= OW_W'(256);
            r_oh   <= OH_W'(256);
            r_mode <= MODE_AVG;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_SIZE: r_ws   <= i_cfg_data[WS_W-1:0];
                REG_OUT_WIDTH:   r_ow   <= i_cfg_data[OW_W-1:0];
                REG_OUT_HEIGHT:  r_oh   <= i_cfg_data[OH_W-1:0];
                REG_MODE:        r_mode <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        if (r_ws == '0) begin
            ws_eff = WS_EFF_W'(1);
        end else if ({1'b0, r_ws} > WS_EFF_W'(MAX_WINDOW)) begin
            ws_eff = WS_EFF_W'(MAX_WINDOW);
        end else begin
            ws_eff = {1'b0, r_ws};
        end
        if (r_ow == '0) begin
            ow_eff = OH_W'(1);
        end else if (OH_W'(r_ow) > OH_W'(MAX_OUT_WIDTH)) begin
            ow_eff = OH_W'(MAX_OUT_WIDTH);
        end else begin
            ow_eff = OH_W'(r_ow);
        end
        if (r_oh == '0) begin
            oh_eff = OH_W'(1);
        end else if (r_oh > OH_W'(MAX_OUT_HEIGHT)) begin
            oh_eff = OH_W'(MAX_OUT_HEIGHT);
        end else begin
            oh_eff = r_oh;
        end
    end

    assign col_ext  = OH_W'(r_col);
    assign last_ciw = (WS_EFF_W'(r_ciw) + WS_EFF_W'(1)) >= ws_eff;
    assign last_riw = (WS_EFF_W'(r_riw) + WS_EFF_W'(1)) >= ws_eff;
    assign last_col = (col_ext + OH_W'(1)) >= ow_eff;
    assign last_row = (OH_W'(r_row) + OH_W'(1)) >= oh_eff;

    // position counter update
    always_comb begin
        n_ciw = r_ciw;
        n_riw = r_riw;
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.accept) begin
            if (i_pix.frame_start) begin
                n_ciw = '0;
                n_riw = '0;
                n_col = '0;
                n_row = '0;
            end
        end else if (i_cmd.calc) begin
            if (!last_ciw) begin
                n_ciw = r_ciw + WIN_W'(1);
            end else begin
                n_ciw = '0;
                if (!last_col) begin
                    n_col = r_col + COL_W'(1);
                end else begin
                    n_col = '0;
                    if (!last_riw) begin
                        n_riw = r_riw + WIN_W'(1);
                    end else begin
                        n_riw = '0;
                        if (!last_row) begin
                            n_row = r_row + ROW_W'(1);
                        end else begin
                            n_row = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ciw <= '0;
            r_riw <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_ciw <= n_ciw;
            r_riw <= n_riw;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pix.pixel & PIX_MASK;
        end
    end

    wpe_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.calc),
        .i_waddr (r_col),
        .i_wdata (n_acc),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    // combine pixel with column accumulator
    assign pix_ext = ACC_W'(r_pix);

    always_comb begin
        if ((r_ciw == '0) && (r_riw == '0)) begin
            n_acc = pix_ext;
        end else begin
            case (r_mode)
                MODE_AVG: n_acc = rd_data + pix_ext;
                MODE_MIN: n_acc = (pix_ext < rd_data) ? pix_ext : rd_data;
                MODE_MAX: n_acc = (pix_ext > rd_data) ? pix_ext : rd_data;
                default:  n_acc = rd_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_acc       <= n_acc;
            r_emit_col  <= col_ext[OCOL_W-1:0];
            r_emit_row  <= r_row;
            r_emit_last <= last_col && last_row;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_dvd[ACC_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_divisor};
    assign q_bit    = (rem_sh >= {1'b0, r_divisor});
    assign n_rem    = q_bit ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_dvd     <= n_acc;
            r_rem     <= '0;
            r_divisor <= DIVR_W'(ws_eff) * DIVR_W'(ws_eff);
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd     <= {r_dvd[ACC_W-2:0], q_bit};
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
    end

    // output word register
    always_comb begin
        case (r_mode)
            MODE_AVG: n_value = r_dvd[PIX_W-1:0];
            MODE_MIN: n_value = r_acc[PIX_W-1:0];
            MODE_MAX: n_value = r_acc[PIX_W-1:0];
            default:  n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.pooled_value  <= n_value;
            r_out.out_col       <= r_emit_col;
            r_out.out_row       <= r_emit_row;
            r_out.last_of_frame <= r_emit_last;
        end
    end

    assign o_status.emit     = last_ciw && last_riw;
    assign o_status.avg      = (r_mode == MODE_AVG);
    assign o_status.div_done = (r_div_cnt == DCNT_W'(ACC_W - 1));
    assign o_status.out_free = !r_out_valid || !i_res_stall;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ----- hdl/window_pooling_engine.sv -----
// ----------------------------------------------------------------------------
// window_pooling_engine
// non-overlapping square window pooling (average, minimum, maximum) over a
// raster pixel stream
//
//   channel   direction  handshake              word
//   pixel     in         i_pix_valid/o_pix_stall   t_pix_word
//   result    out        o_res_valid/i_res_stall   t_res_word
//   config    in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// a pixel is accepted, then the column accumulator ram is read, then the
// value is combined and written back; a window's last pixel then hands off
// the result, in average mode after the bit-serial divider.
// reset clears the position counters and loads register defaults; the
// accumulator ram is not cleared, every window seeds its entry.
// one result word waits in the output register while the next pixel is taken;
// a second finished result waits in the sequencer until that register frees.
// ----------------------------------------------------------------------------
module window_pooling_engine import wpe_pkg::*; #(
    parameter int MAX_OUT_WIDTH = 256,
    parameter int MAX_WINDOW    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_valid,
    output logic                  o_pix_stall,
    input  t_pix_word             i_pix,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output t_res_word             o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    wpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wpe_dp #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_WINDOW    (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_res_stall (i_res_stall),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
